// ===== design/cbt_pkg.sv =====
// Shared types and constants for the cubic Bezier tessellator.
// No dependencies; every other design file refers to it by scoped names.
package cbt_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int T_W        = 17;
    localparam int PROD_W     = T_W + 1 + DIFF_W;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int MAX_POINTS = 64;
    localparam int AXES       = 3;
    localparam int LVL_STAGES = 3;
    localparam int PIPE_DEPTH = 3 * LVL_STAGES;

    localparam logic [T_W-1:0]   ONE_T       = T_W'(65536);
    localparam logic [CNT_W-1:0] CNT_RESET   = CNT_W'(16);
    localparam logic [CNT_W-1:0] CNT_MIN     = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX_MIN = IDX_W'(1);
    localparam logic [IDX_W-1:0] LAST_IDX_MAX = IDX_W'(MAX_POINTS - 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    // t increment per point, indexed by the number of segments (points - 1)
    localparam logic [T_W-1:0] STEP_TABLE [MAX_POINTS] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
        17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,
        17'd4681,  17'd4369,  17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,
        17'd3120,  17'd2978,  17'd2849,  17'd2730,  17'd2621,  17'd2520,  17'd2427,
        17'd2340,  17'd2259,  17'd2184,  17'd2114,  17'd2048,  17'd1985,  17'd1927,
        17'd1872,  17'd1820,  17'd1771,  17'd1724,  17'd1680,  17'd1638,  17'd1598,
        17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,  17'd1365,
        17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191,
        17'd1170,  17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,
        17'd1040
    };

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p0_z;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p1_z;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p2_z;
        coord_t p3_x;
        coord_t p3_y;
        coord_t p3_z;
    } curve_t;

    typedef struct packed {
        coord_t           out_x;
        coord_t           out_y;
        coord_t           out_z;
        logic [IDX_W-1:0] point_index;
        logic             last_point;
    } point_t;

    // Per-point tag that travels down the pipeline with the valid bit
    typedef struct packed {
        logic [T_W-1:0]   t;
        logic [IDX_W-1:0] idx;
        logic             last;
    } meta_t;

endpackage

// ===== design/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator: four 3-D control points in, point_count curve points out.
// Throughput: one point per cycle while m_ready does not stall the pipeline; each curve
// gives n points (n = point_count clamped to 2..64), and the sequencer issues one t value
// per cycle, unless stalled, into a 9-stage pipeline.
// Reset (aresetn, synchronous, active low): pipeline empty, point_count back to 16.
// Depends on cbt_pkg, cbt_point_seq, cbt_casteljau and cbt_lerp.
module cubic_bezier_tessellator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [cbt_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cbt_pkg::curve_t           s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cbt_pkg::point_t           m_data
);

    logic [cbt_pkg::CNT_W-1:0] point_count_reg;
    logic                      m_valid_reg;
    cbt_pkg::point_t           m_data_reg;

    logic            adv;
    logic            issue_valid;
    cbt_pkg::meta_t  issue_meta;
    cbt_pkg::curve_t curve;
    logic            cj_valid;
    cbt_pkg::meta_t  cj_meta;
    cbt_pkg::coord_t cj_x, cj_y, cj_z;

    // Move the whole pipeline whenever the output register can take a point
    assign adv = ~m_valid_reg | m_ready;

    // Point count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= cbt_pkg::CNT_RESET;
        end else if (cfg_wr_en) begin
            point_count_reg <= cfg_wr_data;
        end
    end

    cbt_point_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .point_count (point_count_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .issue_valid (issue_valid),
        .issue_meta  (issue_meta),
        .curve       (curve)
    );

    cbt_casteljau u_casteljau (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (issue_valid),
        .in_meta   (issue_meta),
        .curve     (curve),
        .out_valid (cj_valid),
        .out_meta  (cj_meta),
        .out_x     (cj_x),
        .out_y     (cj_y),
        .out_z     (cj_z)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= cj_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && cj_valid) begin
            m_data_reg.out_x       <= cj_x;
            m_data_reg.out_y       <= cj_y;
            m_data_reg.out_z       <= cj_z;
            m_data_reg.point_index <= cj_meta.idx;
            m_data_reg.last_point  <= cj_meta.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/cbt_lerp.sv =====
// One fixed-point linear interpolation a + floor(t*(b-a)/2^16) in three stages.
// Depends on cbt_pkg.
module cbt_lerp (
    input  logic                          aclk,
    input  logic                          en,
    input  cbt_pkg::coord_t               a,
    input  cbt_pkg::coord_t               b,
    input  logic [cbt_pkg::T_W-1:0]       t,
    output cbt_pkg::coord_t               y
);

    logic signed [cbt_pkg::DIFF_W-1:0] d_reg;
    cbt_pkg::coord_t                   a1_reg;
    logic [cbt_pkg::T_W-1:0]           t1_reg;
    logic signed [cbt_pkg::PROD_W-1:0] prod_reg;
    cbt_pkg::coord_t                   a2_reg;
    cbt_pkg::coord_t                   y_reg;

    logic signed [cbt_pkg::DIFF_W-1:0] d_next;
    logic signed [cbt_pkg::PROD_W-1:0] prod_next;
    logic [cbt_pkg::PROD_W-cbt_pkg::FRAC_W-1:0] sum_next;

    // Difference, product, then floor shift and add
    always_comb begin
        d_next    = cbt_pkg::DIFF_W'(b) - cbt_pkg::DIFF_W'(a);
        prod_next = $signed({1'b0, t1_reg}) * d_reg;
        sum_next  = {{(cbt_pkg::PROD_W - cbt_pkg::FRAC_W - cbt_pkg::COORD_W)
                      {a2_reg[cbt_pkg::COORD_W-1]}},
                     a2_reg} + prod_reg[cbt_pkg::PROD_W-1:cbt_pkg::FRAC_W];
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            a1_reg   <= a;
            t1_reg   <= t;
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
            y_reg    <= sum_next[cbt_pkg::COORD_W-1:0];
        end
    end

    assign y = y_reg;

endmodule

// ===== design/cbt_casteljau.sv =====
// Three de Casteljau levels of cbt_lerp for x, y and z, with valid and tag pipeline.
// Depends on cbt_pkg and cbt_lerp.
module cbt_casteljau (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  cbt_pkg::meta_t      in_meta,
    input  cbt_pkg::curve_t     curve,
    output logic                out_valid,
    output cbt_pkg::meta_t      out_meta,
    output cbt_pkg::coord_t     out_x,
    output cbt_pkg::coord_t     out_y,
    output cbt_pkg::coord_t     out_z
);

    logic           valid_reg [cbt_pkg::PIPE_DEPTH];
    cbt_pkg::meta_t meta_reg  [cbt_pkg::PIPE_DEPTH];

    cbt_pkg::coord_t ctrl [cbt_pkg::AXES][4];
    cbt_pkg::coord_t lvl1 [cbt_pkg::AXES][3];
    cbt_pkg::coord_t lvl2 [cbt_pkg::AXES][2];
    cbt_pkg::coord_t lvl3 [cbt_pkg::AXES];

    // Spread the curve into per-axis control points
    always_comb begin
        ctrl[0][0] = curve.p0_x; ctrl[1][0] = curve.p0_y; ctrl[2][0] = curve.p0_z;
        ctrl[0][1] = curve.p1_x; ctrl[1][1] = curve.p1_y; ctrl[2][1] = curve.p1_z;
        ctrl[0][2] = curve.p2_x; ctrl[1][2] = curve.p2_y; ctrl[2][2] = curve.p2_z;
        ctrl[0][3] = curve.p3_x; ctrl[1][3] = curve.p3_y; ctrl[2][3] = curve.p3_z;
    end

    // Interpolation cells, one per lerp of each level
    for (genvar ax = 0; ax < cbt_pkg::AXES; ax++) begin : g_axis
        for (genvar j = 0; j < 3; j++) begin : g_l1
            cbt_lerp u_lerp (
                .aclk (aclk), .en (adv),
                .a (ctrl[ax][j]), .b (ctrl[ax][j+1]), .t (in_meta.t),
                .y (lvl1[ax][j])
            );
        end
        for (genvar j = 0; j < 2; j++) begin : g_l2
            cbt_lerp u_lerp (
                .aclk (aclk), .en (adv),
                .a (lvl1[ax][j]), .b (lvl1[ax][j+1]),
                .t (meta_reg[cbt_pkg::LVL_STAGES-1].t),
                .y (lvl2[ax][j])
            );
        end
        cbt_lerp u_lerp_l3 (
            .aclk (aclk), .en (adv),
            .a (lvl2[ax][0]), .b (lvl2[ax][1]),
            .t (meta_reg[2*cbt_pkg::LVL_STAGES-1].t),
            .y (lvl3[ax])
        );
    end

    // Shift valid bits and tags alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cbt_pkg::PIPE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < cbt_pkg::PIPE_DEPTH; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta_reg[0] <= in_meta;
            for (int i = 1; i < cbt_pkg::PIPE_DEPTH; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[cbt_pkg::PIPE_DEPTH-1];
    assign out_meta  = meta_reg[cbt_pkg::PIPE_DEPTH-1];
    assign out_x     = lvl3[0];
    assign out_y     = lvl3[1];
    assign out_z     = lvl3[2];

endmodule

// ===== design/cbt_point_seq.sv =====
// Point sequencer: holds one curve and issues one t value per cycle while the pipeline advances.
// Depends on cbt_pkg.
module cbt_point_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic [cbt_pkg::CNT_W-1:0] point_count,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cbt_pkg::curve_t           s_data,
    output logic                      issue_valid,
    output cbt_pkg::meta_t            issue_meta,
    output cbt_pkg::curve_t           curve
);

    logic                      busy_reg, busy_next;
    logic [cbt_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [cbt_pkg::T_W-1:0]   t_reg, t_next;
    logic [cbt_pkg::IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [cbt_pkg::T_W-1:0]   step_reg, step_next;
    cbt_pkg::curve_t           curve_reg;

    logic is_last;
    logic issue;
    logic take;

    // Clamp the point count and look up the t increment
    always_comb begin
        if (point_count < cbt_pkg::CNT_MIN) begin
            last_idx_next = cbt_pkg::LAST_IDX_MIN;
        end else if (point_count > cbt_pkg::CNT_MAX) begin
            last_idx_next = cbt_pkg::LAST_IDX_MAX;
        end else begin
            last_idx_next = cbt_pkg::IDX_W'(point_count - 7'd1);
        end
        step_next = cbt_pkg::STEP_TABLE[last_idx_next];
    end

    assign is_last = (idx_reg == last_idx_reg);
    assign issue   = busy_reg & adv;
    assign s_ready = ~busy_reg | (issue & is_last);
    assign take    = s_valid & s_ready;

    // Start a curve on transfer, otherwise advance while the pipeline moves
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        t_next    = t_reg;
        if (take) begin
            busy_next = 1'b1;
            idx_next  = '0;
            t_next    = '0;
        end else if (issue) begin
            idx_next = idx_reg + 6'd1;
            t_next   = t_reg + step_reg;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            t_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            t_reg    <= t_next;
        end
    end

    // Hold the curve and its count settings
    always_ff @(posedge aclk) begin
        if (take) begin
            curve_reg    <= s_data;
            last_idx_reg <= last_idx_next;
            step_reg     <= step_next;
        end
    end

    // Force the final point to t = 1
    always_comb begin
        issue_meta.t    = is_last ? cbt_pkg::ONE_T : t_reg;
        issue_meta.idx  = idx_reg;
        issue_meta.last = is_last;
    end

    assign issue_valid = busy_reg;
    assign curve       = curve_reg;

endmodule
